// File: src/assert_macros.svh
// assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/iips_pkg.sv
// ----------------------------------------------------------------------------
// iips_pkg
// Shared constants and types of the sensor polling sequencer.
// ----------------------------------------------------------------------------
package iips_pkg;

   localparam int SAMPLE_BYTES_DEF    = 14;
   localparam int RECOVERY_PULSES_DEF = 9;

   localparam logic [7:0] DEV_ADDR_MAIN = 8'h68;
   localparam logic [7:0] DEV_ADDR_ALT  = 8'h69;
   localparam logic [7:0] REG_WHO_AM_I  = 8'h75;
   localparam logic [7:0] REG_DATA      = 8'h3B;
   localparam logic [7:0] REG_PWR       = 8'h6B;
   localparam logic [7:0] REG_FILTER    = 8'h1A;
   localparam logic [7:0] REG_RATE      = 8'h19;
   localparam logic [7:0] REG_GYRO      = 8'h1B;
   localparam logic [7:0] REG_ACCEL     = 8'h1C;

   // configuration register indexes
   localparam logic [2:0] CSR_PERIOD = 3'd0;
   localparam logic [2:0] CSR_FILTER = 3'd1;
   localparam logic [2:0] CSR_RATE   = 3'd2;
   localparam logic [2:0] CSR_GYRO   = 3'd3;
   localparam logic [2:0] CSR_ACCEL  = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_ADDR  = 2'd1;
   localparam logic [1:0] ERR_REG   = 2'd2;
   localparam logic [1:0] ERR_RDADR = 2'd3;

   typedef struct packed {
      logic       sda_level;
      logic       ms_tick;
   } req_type;

   typedef struct packed {
      logic        scl_release;
      logic        sda_release;
      logic        word_valid;
      logic [2:0]  word_index;
      logic signed [15:0] word_value;
      logic        cycle_done;
      logic        read_good;
      logic [1:0]  error_code;
      logic        overrun;
      logic        address_alternate;
      logic [7:0]  identity;
   } rsp_type;

endpackage

// File: src/iips_stream_if.sv
// ----------------------------------------------------------------------------
// iips_stream_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
interface iips_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/i2c_imu_poll_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_imu_poll_sequencer_core
// Open-drain bus master that probes, sets up and polls a motion sensor.
// ----------------------------------------------------------------------------
// Each request beat is one bus timing quantum and gives exactly one response
// beat in the following cycle with the SCL/SDA drive and any published word or period
// report. One beat is taken every cycle; the single result register, free or
// being emptied in the same cycle, is the only thing that can hold a request
// back. Configuration writes must be made while the block is idle.
module i2c_imu_poll_sequencer_core
   import iips_pkg::*;
#(
   parameter int SAMPLE_BYTES    = SAMPLE_BYTES_DEF,
   parameter int RECOVERY_PULSES = RECOVERY_PULSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   iips_stream_if.sink   req,
   iips_stream_if.source rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic        full_ff;
   logic        step;
   logic [15:0] period_ff;
   logic [7:0]  filter_ff, rate_ff, gyro_ff, accel_ff;
   rsp_type     result;

   assign req.ready = !full_ff || rsp.ready;
   assign step      = req.valid && req.ready;
   assign rsp.valid = full_ff;
   assign rsp.data  = result;

   // result occupancy
   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else if (step) full_ff <= 1'b1;
      else if (rsp.ready) full_ff <= 1'b0;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd20; filter_ff <= 8'd3; rate_ff <= 8'd19;
         gyro_ff <= 8'd0; accel_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PERIOD: period_ff <= csr_data;
            CSR_FILTER: filter_ff <= csr_data[7:0];
            CSR_RATE:   rate_ff   <= csr_data[7:0];
            CSR_GYRO:   gyro_ff   <= csr_data[7:0];
            CSR_ACCEL:  accel_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   iips_engine #(
      .SAMPLE_BYTES(SAMPLE_BYTES), .RECOVERY_PULSES(RECOVERY_PULSES)
   ) u_engine (
      .clock(clock), .reset(reset), .step(step), .req(req.data),
      .period(period_ff), .filter_setting(filter_ff), .rate_divider(rate_ff),
      .gyro_range(gyro_ff), .accel_range(accel_ff), .rsp(result)
   );

endmodule

// File: src/iips_engine.sv
// ----------------------------------------------------------------------------
// iips_engine
// Bus sequencer state: takes one line quantum per beat, gives next result.
// ----------------------------------------------------------------------------
module iips_engine
   import iips_pkg::*;
#(
   parameter int SAMPLE_BYTES    = SAMPLE_BYTES_DEF,
   parameter int RECOVERY_PULSES = RECOVERY_PULSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     req,
   input  logic [15:0] period,
   input  logic [7:0]  filter_setting,
   input  logic [7:0]  rate_divider,
   input  logic [7:0]  gyro_range,
   input  logic [7:0]  accel_range,
   output rsp_type     rsp
);

   typedef enum logic [2:0] {
      JOB_RECOVER, JOB_PROBE, JOB_SETUP, JOB_BURST, JOB_WAIT
   } job_type;

   typedef enum logic [2:0] {
      OP_RELEASE, OP_PULSE, OP_START, OP_WRITE, OP_READ, OP_STOP, OP_IDLE
   } op_type;

   localparam logic [3:0] LAST_BYTE  = 4'(SAMPLE_BYTES - 1);
   localparam logic [3:0] LAST_PULSE = 4'(RECOVERY_PULSES - 1);

   job_type     phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   logic [4:0]  step_ff, step_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  byte_ff, byte_in;
   logic [2:0]  pub_ff, pub_in;
   logic [31:0] ms_ff, ms_in;
   logic [31:0] due_ff, due_in;
   logic        alt_ff, alt_in;
   logic [7:0]  ident_ff, ident_in;
   logic [1:0]  perr_ff, perr_in;
   logic        late_ff, late_in;
   logic [2:0]  sidx_ff, sidx_in;
   logic        startup_ff, startup_in;
   logic        scl_ff, scl_in, sda_ff, sda_in;
   logic [15:0] store_ff [7];
   logic        store_we;
   logic [2:0]  store_wa;
   logic [15:0] store_wd;
   rsp_type     rsp_in;

   op_type      kind;
   logic [7:0]  wval;
   logic [7:0]  dev;
   logic [31:0] diff;
   logic [4:0]  s;
   logic        done, nack;

   // current operation of the job
   always_comb begin
      case (phase_ff)
         JOB_RECOVER: kind = (op_ff == 3'd0) ? OP_RELEASE :
                             ((op_ff == 3'd1) ? OP_PULSE : OP_STOP);
         JOB_SETUP:   kind = (op_ff == 3'd0) ? OP_START :
                             ((op_ff >= 3'd4) ? OP_STOP : OP_WRITE);
         JOB_PROBE, JOB_BURST: begin
            if (op_ff == 3'd0 || op_ff == 3'd3) kind = OP_START;
            else if (op_ff == 3'd5)            kind = OP_READ;
            else if (op_ff >= 3'd6)            kind = OP_STOP;
            else                               kind = OP_WRITE;
         end
         default:     kind = OP_IDLE;
      endcase
   end

   // byte to send for the current write
   always_comb begin
      dev = alt_ff ? DEV_ADDR_ALT : DEV_ADDR_MAIN;
      if (op_ff == 3'd1) wval = {dev[6:0], 1'b0};
      else if (phase_ff == JOB_SETUP) begin
         if (op_ff == 3'd2) begin
            case (sidx_ff)
               3'd1:    wval = REG_FILTER;
               3'd2:    wval = REG_RATE;
               3'd3:    wval = REG_GYRO;
               3'd4:    wval = REG_ACCEL;
               default: wval = REG_PWR;
            endcase
         end else begin
            case (sidx_ff)
               3'd1:    wval = filter_setting;
               3'd2:    wval = rate_divider;
               3'd3:    wval = gyro_range;
               3'd4:    wval = accel_range;
               default: wval = 8'h00;
            endcase
         end
      end else if (op_ff == 3'd2) wval = (phase_ff == JOB_PROBE) ? REG_WHO_AM_I : REG_DATA;
      else wval = {dev[6:0], 1'b1};
   end

   // next state for one quantum
   always_comb begin
      phase_in = phase_ff; op_in = op_ff; step_in = step_ff; shift_in = shift_ff;
      byte_in = byte_ff; pub_in = pub_ff; due_in = due_ff; alt_in = alt_ff;
      ident_in = ident_ff; perr_in = perr_ff; late_in = late_ff; sidx_in = sidx_ff;
      startup_in = startup_ff; scl_in = scl_ff; sda_in = sda_ff;
      store_we = 1'b0; store_wa = byte_ff[3:1]; store_wd = '0;
      rsp_in = '0;
      done = 1'b0; nack = 1'b0; s = step_ff;
      ms_in = ms_ff + {31'd0, req.ms_tick};
      diff = ms_in - due_ff;

      // publishing runs beside bus work
      if (pub_ff != 3'd0) begin
         rsp_in.word_valid = 1'b1;
         rsp_in.word_index = 3'd7 - pub_ff;
         rsp_in.word_value = store_ff[3'd7 - pub_ff];
         pub_in = pub_ff - 3'd1;
      end

      if (phase_ff == JOB_WAIT) begin
         scl_in = 1'b1; sda_in = 1'b1;
         if (!diff[31]) begin
            if (diff >= {16'd0, period}) begin late_in = 1'b1; due_in = ms_in; end
            else late_in = 1'b0;
            perr_in = ERR_NONE;
            op_in = '0; step_in = '0; byte_in = '0;
            if (ident_ff == DEV_ADDR_MAIN || ident_ff == DEV_ADDR_ALT) phase_in = JOB_BURST;
            else begin alt_in = 1'b0; phase_in = JOB_PROBE; end
         end
      end else if (kind == OP_IDLE) begin
         phase_in = JOB_WAIT; op_in = '0; step_in = '0; byte_in = '0;
      end else begin
         // one quantum of the operation
         step_in = step_ff + 5'd1;
         case (kind)
            OP_RELEASE: begin scl_in = 1'b1; sda_in = 1'b1; done = 1'b1; end
            OP_PULSE: begin
               if (s == 5'd0) scl_in = 1'b0;
               else begin scl_in = 1'b1; done = 1'b1; end
            end
            OP_START: begin
               if (s == 5'd0) begin scl_in = 1'b1; sda_in = 1'b1; end
               else if (s == 5'd1) sda_in = 1'b0;
               else begin scl_in = 1'b0; done = 1'b1; end
            end
            OP_STOP: begin
               if (s == 5'd0) sda_in = 1'b0;
               else if (s == 5'd1) scl_in = 1'b1;
               else begin sda_in = 1'b1; done = 1'b1; end
            end
            OP_WRITE: begin
               if (s < 5'd24) begin
                  logic [7:0] sb;
                  logic [4:0] q;
                  logic [4:0] sub;
                  sb = (s == 5'd0) ? wval : shift_ff;
                  q = 5'((8'(s) * 8'd11) >> 5);
                  sub = s - 5'(q * 5'd3);
                  shift_in = sb;
                  if (sub == 5'd0) sda_in = sb[7];
                  else if (sub == 5'd1) scl_in = 1'b1;
                  else begin scl_in = 1'b0; shift_in = {sb[6:0], 1'b0}; end
               end else if (s == 5'd24) sda_in = 1'b1;
               else if (s == 5'd25) scl_in = 1'b1;
               else begin nack = req.sda_level; scl_in = 1'b0; done = 1'b1; end
            end
            OP_READ: begin
               if (s == 5'd0) begin sda_in = 1'b1; shift_in = 8'h00; end
               else if (s <= 5'd16) begin
                  if (s[0]) scl_in = 1'b1;
                  else begin shift_in = {shift_ff[6:0], req.sda_level}; scl_in = 1'b0; end
               end else if (s == 5'd17)
                  sda_in = (phase_ff != JOB_BURST || byte_ff >= LAST_BYTE);
               else if (s == 5'd18) scl_in = 1'b1;
               else if (s == 5'd19) scl_in = 1'b0;
               else begin sda_in = 1'b1; done = 1'b1; end
            end
            default: ;
         endcase

         // end of an operation
         if (done) begin
            step_in = '0;
            case (kind)
               OP_RELEASE: begin op_in = 3'd1; byte_in = '0; end
               OP_PULSE: begin
                  if (byte_ff >= LAST_PULSE) op_in = 3'd2;
                  else byte_in = byte_ff + 4'd1;
               end
               OP_START: op_in = op_ff + 3'd1;
               OP_WRITE: begin
                  if (nack) begin
                     logic [1:0] code;
                     code = (op_ff == 3'd4) ? ERR_RDADR : op_ff[1:0];
                     if (phase_ff == JOB_SETUP) begin
                        perr_in = perr_ff | code; op_in = 3'd4;
                     end else begin
                        perr_in = code; op_in = 3'd6;
                     end
                  end else op_in = op_ff + 3'd1;
               end
               OP_READ: begin
                  if (phase_ff == JOB_PROBE) begin
                     ident_in = shift_ff; op_in = 3'd6;
                  end else begin
                     if (byte_ff[3:1] != 3'd7) begin
                        store_we = 1'b1;
                        store_wd = byte_ff[0] ? {store_ff[byte_ff[3:1]][15:8], shift_ff}
                                              : {shift_ff, 8'h00};
                     end
                     if (byte_ff >= LAST_BYTE) op_in = 3'd6;
                     else byte_in = byte_ff + 4'd1;
                  end
               end
               OP_STOP: begin
                  logic fin, good;
                  fin = 1'b0; good = 1'b0;
                  op_in = '0; byte_in = '0;
                  case (phase_ff)
                     JOB_RECOVER: begin
                        alt_in = 1'b0; perr_in = ERR_NONE; phase_in = JOB_PROBE;
                     end
                     JOB_PROBE: begin
                        if (perr_ff != ERR_NONE && !alt_ff) begin
                           alt_in = 1'b1; perr_in = ERR_NONE;
                        end else if (perr_ff == ERR_NONE) begin
                           sidx_in = 3'd0; phase_in = JOB_SETUP;
                        end else fin = 1'b1;
                     end
                     JOB_SETUP: begin
                        sidx_in = sidx_ff + 3'd1;
                        if (sidx_ff == 3'd4) fin = 1'b1;
                     end
                     default: begin fin = 1'b1; good = (perr_ff == ERR_NONE); end
                  endcase
                  if (fin) begin
                     phase_in = JOB_WAIT;
                     if (startup_ff) begin
                        startup_in = 1'b0;
                        due_in = ms_in + {16'd0, period};
                     end else begin
                        rsp_in.cycle_done = 1'b1;
                        rsp_in.read_good = good;
                        rsp_in.error_code = perr_ff;
                        rsp_in.overrun = late_ff;
                        if (good) pub_in = 3'd7;
                        due_in = due_ff + {16'd0, period};
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      rsp_in.scl_release = scl_in;
      rsp_in.sda_release = sda_in;
      rsp_in.address_alternate = alt_in;
      rsp_in.identity = ident_in;
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= JOB_RECOVER; op_ff <= '0; step_ff <= '0; shift_ff <= '0;
         byte_ff <= '0; pub_ff <= '0; ms_ff <= '0; due_ff <= 32'd20;
         alt_ff <= 1'b0; ident_ff <= '0; perr_ff <= '0; late_ff <= 1'b0;
         sidx_ff <= '0; startup_ff <= 1'b1; scl_ff <= 1'b1; sda_ff <= 1'b1;
         rsp <= '0;
      end else if (step) begin
         phase_ff <= phase_in; op_ff <= op_in; step_ff <= step_in; shift_ff <= shift_in;
         byte_ff <= byte_in; pub_ff <= pub_in; ms_ff <= ms_in; due_ff <= due_in;
         alt_ff <= alt_in; ident_ff <= ident_in; perr_ff <= perr_in; late_ff <= late_in;
         sidx_ff <= sidx_in; startup_ff <= startup_in; scl_ff <= scl_in; sda_ff <= sda_in;
         rsp <= rsp_in;
      end
   end

   // word store
   always_ff @(posedge clock) begin
      if (step && store_we) store_ff[store_wa] <= store_wd;
   end

endmodule

// File: src/iips_checker.sv
// ----------------------------------------------------------------------------
// iips_checker
// Port-level checks of the polling sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module iips_checker
   import iips_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic beat_in, rsp_stalled, word_shown, report_idle, report_clear;

   // handshake and payload terms
   assign beat_in      = req_valid && req_ready;
   assign rsp_stalled  = rsp_valid && !rsp_ready;
   assign word_shown   = rsp_valid && rsp_data.word_valid;
   assign report_idle  = rsp_valid && !rsp_data.cycle_done;
   assign report_clear = !rsp_data.read_good && rsp_data.error_code == ERR_NONE &&
                         !rsp_data.overrun;

   `CHK_NEXT(a_beat_gives_rsp, clock, reset, beat_in, rsp_valid, "no response")
   `CHK_IMPLY(a_word_idx, clock, reset, word_shown, rsp_data.word_index <= 3'd6, "bad index")
   `CHK_IMPLY(a_report_quiet, clock, reset, report_idle, report_clear, "stray report")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_data), "rsp moved")

endmodule

bind i2c_imu_poll_sequencer_core iips_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
